// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define MBX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mailbox assertion failed");

// Concurrent check that also holds during reset.
`define MBX_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mailbox reset assertion failed");

`endif

// ===== rtl/core/mbx_pkg.sv =====
// Package with the types and constants of the dual-core mailbox.
package mbx_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int DATA_W     = 32;
    localparam int WAIT_W     = 4;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_DRAIN = 2'd2;

    typedef struct packed {
        logic              core;
        logic [1:0]        mode;
        logic [DATA_W-1:0] wr_data;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] rd_data;
        logic [WAIT_W-1:0] waiting;
        logic              doorbell;
        logic              doorbell_channel;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ring_ctl_t;

    typedef struct packed {
        logic              ok;
        logic [WAIT_W-1:0] waiting;
        logic              doorbell;
        logic              doorbell_channel;
        logic              pop_ok;
        logic              pop_core;
    } meta_t;

endpackage

// ===== rtl/core/mbx_ring.sv =====
// Ring storage for one mailbox direction with a registered read port.
module mbx_ring (
    input  logic                          aclk,
    input  mbx_pkg::ring_ctl_t            ctl,
    output logic [mbx_pkg::DATA_W-1:0]    rd_data
);
    import mbx_pkg::*;

    logic [DATA_W-1:0] mem_reg [RING_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem_reg[ctl.waddr] <= ctl.wdata;
        end
        if (ctl.re) begin
            rd_data_reg <= mem_reg[ctl.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mbx_ctrl.sv =====
// Ring pointers, full and empty decisions, and result status register.
module mbx_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  mbx_pkg::req_t      req,
    output mbx_pkg::ring_ctl_t ring0_ctl,
    output mbx_pkg::ring_ctl_t ring1_ctl,
    output mbx_pkg::meta_t     meta
);
    import mbx_pkg::*;

    logic [PTR_W-1:0] wp_reg [2];
    logic [PTR_W-1:0] rp_reg [2];
    logic [PTR_W-1:0] wp_next [2];
    logic [PTR_W-1:0] rp_next [2];
    logic [PTR_W-1:0] push_ptr;
    logic [PTR_W-1:0] fill;
    logic             rx;
    logic             tx;
    logic             full;
    logic             empty;
    ring_ctl_t        ctl [2];
    meta_t            meta_reg;
    meta_t            meta_next;

    assign rx = req.core;
    assign tx = ~req.core;

    always_comb begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        meta_next = '0;
        ctl[0]    = '0;
        ctl[1]    = '0;
        push_ptr  = wp_reg[tx] + PTR_W'(1);
        full      = (push_ptr == rp_reg[tx]);
        empty     = (rp_reg[rx] == wp_reg[rx]);
        case (req.mode)
            MODE_PUSH: begin
                if (!full) begin
                    wp_next[tx]                = push_ptr;
                    meta_next.ok               = 1'b1;
                    meta_next.doorbell         = 1'b1;
                    meta_next.doorbell_channel = req.core;
                    ctl[tx].we                 = fire;
                    ctl[tx].waddr              = wp_reg[tx];
                    ctl[tx].wdata              = req.wr_data;
                end
            end
            MODE_POP: begin
                if (!empty) begin
                    rp_next[rx]      = rp_reg[rx] + PTR_W'(1);
                    meta_next.ok     = 1'b1;
                    meta_next.pop_ok = 1'b1;
                    ctl[rx].re       = fire;
                    ctl[rx].raddr    = rp_reg[rx];
                end
            end
            MODE_DRAIN: begin
                rp_next[rx] = wp_reg[rx];
            end
            default: begin
            end
        endcase
        fill               = wp_next[rx] - rp_next[rx];
        meta_next.waiting  = WAIT_W'(fill);
        meta_next.pop_core = req.core;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg[0] <= '0;
            wp_reg[1] <= '0;
            rp_reg[0] <= '0;
            rp_reg[1] <= '0;
        end else if (fire) begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            meta_reg <= meta_next;
        end
    end

    assign ring0_ctl = ctl[0];
    assign ring1_ctl = ctl[1];
    assign meta      = meta_reg;

endmodule

// ===== rtl/core/dual_core_mailbox_fifo.sv =====
// Results are registered. Throughput: one request per cycle while no reply is held back
// by m_ready; the input register and the ring pointer update with its buffer access set
// that figure, and each ring has one write and one read port. Reset clears the ring
// pointers and both valid flags; ring contents stay undefined until written, and
// requests are taken as soon as reset is released.
module dual_core_mailbox_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mbx_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output mbx_pkg::rsp_t m_rsp
);
    import mbx_pkg::*;

    logic              in_valid_reg;
    req_t              req_reg;
    logic              m_valid_reg;
    logic              advance;
    logic              fire;
    ring_ctl_t         ring0_ctl;
    ring_ctl_t         ring1_ctl;
    meta_t             meta;
    logic [DATA_W-1:0] ring0_rd;
    logic [DATA_W-1:0] ring1_rd;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    mbx_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .req       (req_reg),
        .ring0_ctl (ring0_ctl),
        .ring1_ctl (ring1_ctl),
        .meta      (meta)
    );

    mbx_ring u_ring_to_core0 (
        .aclk    (aclk),
        .ctl     (ring0_ctl),
        .rd_data (ring0_rd)
    );

    mbx_ring u_ring_to_core1 (
        .aclk    (aclk),
        .ctl     (ring1_ctl),
        .rd_data (ring1_rd)
    );

    always_comb begin
        m_rsp                  = '0;
        m_rsp.ok               = meta.ok;
        m_rsp.waiting          = meta.waiting;
        m_rsp.doorbell         = meta.doorbell;
        m_rsp.doorbell_channel = meta.doorbell_channel;
        if (meta.pop_ok) begin
            m_rsp.rd_data = meta.pop_core ? ring1_rd : ring0_rd;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/mbx_chk.sv =====
// Port-level checker for the dual-core mailbox and its bind statement.
`include "assert_macros.svh"

module mbx_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input mbx_pkg::req_t s_req,
    input logic          m_valid,
    input logic          m_ready,
    input mbx_pkg::rsp_t m_rsp
);
    import mbx_pkg::*;

    `MBX_ASSERT(a_bell_needs_ok, aclk, aresetn, m_valid && m_rsp.doorbell |-> m_rsp.ok)
    `MBX_ASSERT(a_data_only_on_pop, aclk, aresetn,
        m_valid && (m_rsp.rd_data != '0) |-> m_rsp.ok && !m_rsp.doorbell)
    `MBX_ASSERT(a_chan_only_with_bell, aclk, aresetn,
        m_valid && m_rsp.doorbell_channel |-> m_rsp.doorbell)
    `MBX_ASSERT(a_rsp_held, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
    `MBX_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule

bind dual_core_mailbox_fifo mbx_chk u_chk (.*);

// ===== test/mailbox_checker.sv =====
// Checker that predicts every mailbox reply from the accepted requests and compares it.
module mailbox_checker
    import mbx_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_req,
    input  logic m_valid,
    input  logic m_ready,
    input  rsp_t m_rsp,
    output int   errors,
    output int   pending,
    output int   checked,
    output int   refused
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 50;

    logic [DATA_W-1:0] ring [2][RING_DEPTH];
    logic [PTR_W-1:0]  wr_ptr [2];
    logic [PTR_W-1:0]  rd_ptr [2];
    rsp_t              replies_due [$];
    int                fail_cnt = 0;
    int                check_cnt = 0;
    int                refuse_cnt = 0;

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
        refused = 0;
    end

    function automatic rsp_t mailbox_step(input req_t req);
        rsp_t             rsp;
        logic             me;
        logic             peer;
        logic [PTR_W-1:0] fill;
        rsp  = '0;
        me   = req.core;
        peer = ~req.core;
        case (req.mode)
            MODE_PUSH: begin
                if (PTR_W'(wr_ptr[peer] + 1'b1) != rd_ptr[peer]) begin
                    ring[peer][wr_ptr[peer]] = req.wr_data;
                    wr_ptr[peer] = PTR_W'(wr_ptr[peer] + 1'b1);
                    rsp.ok = 1'b1;
                    rsp.doorbell = 1'b1;
                    rsp.doorbell_channel = me;
                end
            end
            MODE_POP: begin
                if (rd_ptr[me] != wr_ptr[me]) begin
                    rsp.rd_data = ring[me][rd_ptr[me]];
                    rd_ptr[me] = PTR_W'(rd_ptr[me] + 1'b1);
                    rsp.ok = 1'b1;
                end
            end
            MODE_DRAIN: begin
                rd_ptr[me] = wr_ptr[me];
            end
            default: begin
            end
        endcase
        fill = PTR_W'(wr_ptr[me] - rd_ptr[me]);
        rsp.waiting = WAIT_W'(fill);
        return rsp;
    endfunction

    task automatic report(input string what, input logic [DATA_W-1:0] got,
                          input logic [DATA_W-1:0] want);
        fail_cnt++;
        if (fail_cnt <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : watch
        rsp_t want;
        if (!aresetn) begin
            wr_ptr[0] = '0;
            wr_ptr[1] = '0;
            rd_ptr[0] = '0;
            rd_ptr[1] = '0;
            replies_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    report("reply with no request outstanding, rd_data", m_rsp.rd_data, '0);
                end else begin
                    want = replies_due.pop_front();
                    check_cnt++;
                    if (m_rsp.ok !== want.ok)
                        report("ok", DATA_W'(m_rsp.ok), DATA_W'(want.ok));
                    if (m_rsp.rd_data !== want.rd_data)
                        report("rd_data", m_rsp.rd_data, want.rd_data);
                    if (m_rsp.waiting !== want.waiting)
                        report("waiting", DATA_W'(m_rsp.waiting), DATA_W'(want.waiting));
                    if (m_rsp.doorbell !== want.doorbell)
                        report("doorbell", DATA_W'(m_rsp.doorbell), DATA_W'(want.doorbell));
                    if (m_rsp.doorbell_channel !== want.doorbell_channel)
                        report("doorbell_channel", DATA_W'(m_rsp.doorbell_channel),
                               DATA_W'(want.doorbell_channel));
                end
            end
            if (s_valid && s_ready) begin
                want = mailbox_step(s_req);
                if (s_req.mode == MODE_PUSH && !want.ok) refuse_cnt++;
                replies_due.push_back(want);
            end
        end
        errors  <= fail_cnt;
        pending <= replies_due.size();
        checked <= check_cnt;
        refused <= refuse_cnt;
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the mailbox testbench: clock, reset, request and reply traffic, and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbx_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 8;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req   = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    int errors;
    int pending;
    int checked;
    int refused;
    int src_idle = 14;
    int snk_idle = 76;
    int sent = 0;
    int cycles = 0;
    int sent_by_mode [4] = '{0, 0, 0, 0};
    bit hold_off = 1'b0;

    dual_core_mailbox_fifo dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    mailbox_checker u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp),
        .errors  (errors),
        .pending (pending),
        .checked (checked),
        .refused (refused)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d replies outstanding", cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    always begin
        @(posedge aclk);
        if (hold_off) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_off = 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    function automatic req_t make_req(input logic core, input logic [1:0] mode,
                                      input logic [DATA_W-1:0] data);
        req_t req;
        req.core    = core;
        req.mode    = mode;
        req.wr_data = data;
        return req;
    endfunction

    function automatic req_t random_request(input logic burst_core, input int push_pct);
        req_t req;
        int   pick;
        req.core = ($urandom_range(9) < 7) ? burst_core : 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 3) req.mode = MODE_NOP;
        else if (pick < 9) req.mode = MODE_DRAIN;
        else if ($urandom_range(99) < push_pct) req.mode = MODE_PUSH;
        else req.mode = MODE_POP;
        case ($urandom_range(7))
            0: req.wr_data = '0;
            1: req.wr_data = '1;
            default: req.wr_data = $urandom;
        endcase
        return req;
    endfunction

    task automatic send(input req_t req);
        if ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        sent_by_mode[req.mode]++;
    endtask

    task automatic directed_requests();
        for (int i = 0; i < RING_DEPTH; i++) begin
            if (i == 0) send(make_req(1'b0, MODE_PUSH, '0));
            else if (i == 1) send(make_req(1'b0, MODE_PUSH, '1));
            else send(make_req(1'b0, MODE_PUSH, $urandom));
        end
        send(make_req(1'b1, MODE_POP, '1));
        send(make_req(1'b1, MODE_NOP, $urandom));
        send(make_req(1'b1, MODE_DRAIN, '1));
        send(make_req(1'b1, MODE_POP, $urandom));
        send(make_req(1'b0, MODE_POP, '0));
        send(make_req(1'b0, MODE_DRAIN, $urandom));
        send(make_req(1'b1, MODE_PUSH, 32'hA5A5_A5A5));
        send(make_req(1'b0, MODE_POP, '0));
    endtask

    task automatic random_requests(input int count, input bit with_hold);
        int   first;
        int   burst_len;
        int   push_pct;
        logic burst_core;
        bit   held;
        first = sent;
        held  = 1'b0;
        while (sent < first + count) begin
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            burst_core = 1'($urandom_range(1));
            burst_len  = $urandom_range(1, 24);
            repeat (burst_len) begin
                if (with_hold && !held && sent >= first + 100) begin
                    hold_off = 1'b1;
                    held = 1'b1;
                end
                send(random_request(burst_core, push_pct));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        directed_requests();
        random_requests(380, 1'b1);
        src_idle = 76;
        snk_idle = 14;
        random_requests(380, 1'b0);
        src_idle = 0;
        snk_idle = 0;
        random_requests(390, 1'b0);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("sent %0d requests: %0d push, %0d pop, %0d drain, %0d unused mode",
                 sent, sent_by_mode[MODE_PUSH], sent_by_mode[MODE_POP],
                 sent_by_mode[MODE_DRAIN], sent_by_mode[MODE_NOP]);
        $display("checked %0d replies, %0d pushes refused on a full ring, %0d mismatches",
                 checked, refused, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mbx_pkg.sv
rtl/core/mbx_ring.sv
rtl/core/mbx_ctrl.sv
rtl/core/dual_core_mailbox_fifo.sv
rtl/core/mbx_chk.sv
test/mailbox_checker.sv
test/tb_top.sv
